>>> rtl/core/broken_link_aging_table_assert.svh
// assertion macros for the broken link aging table
`ifndef BROKEN_LINK_AGING_TABLE_ASSERT_SVH
`define BROKEN_LINK_AGING_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BLAT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("assertion failed");
`define BLAT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error("fail");
`else
`define BLAT_ASSERT(label, prop)
`define BLAT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/blat_pkg.sv
// ----------------------------------------------------------------------------
// blat_pkg
// types and constants of the broken link aging table
// ----------------------------------------------------------------------------
package blat_pkg;
	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int ENTRY_W = 1 + 6 * 32;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_FIND_SD = 3'd1;
	localparam logic [2:0] CMD_FIND_D = 3'd2;
	localparam logic [2:0] CMD_EXPIRE = 3'd3;
	localparam logic [2:0] CMD_SWEEP = 3'd4;
	localparam logic [2:0] CMD_CLEAR = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic REG_LIFETIME = 1'b0;
	localparam logic REG_DELETE = 1'b1;

	typedef struct packed {
		logic [2:0] cmd;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] prev_hop;
		logic [31:0] last_available;
		logic [31:0] now_time;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] hit_src;
		logic [31:0] hit_dst;
		logic [31:0] hit_prev_hop;
		logic [31:0] hit_last_available;
		logic hit_active;
		logic [31:0] hit_lifetime;
		logic [5:0] expired_count;
		logic [5:0] removed_count;
	} rsp_t;

	typedef struct packed {
		logic active;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] prev_hop;
		logic [31:0] last_available;
		logic [31:0] deadline;
		logic [31:0] stamp;
	} entry_t;
endpackage

>>> rtl/core/blat_ram.sv
// ----------------------------------------------------------------------------
// blat_ram
// generic ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module blat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/core/broken_link_aging_table.sv
// ----------------------------------------------------------------------------
// broken_link_aging_table
// aging table of broken routes with lookup, expiry and sweep
// ----------------------------------------------------------------------------
// Each request walks all TABLE_ENTRIES slots of the entry ram, one slot
// read per cycle, and writes back the slots it changes. The response is
// registered when the walk is finished, and the next request is taken only
// after that; the walk length is set by the single read port of the entry ram.
// The response sits in an output register, so the next request is taken
// while the response waits; a finished walk holds in its last state only
// while an earlier response is still not taken. Used bits live in flip-flops
// cleared by reset; entry contents are used only for used slots. No clearing
// pass is needed after reset.
module broken_link_aging_table
	import blat_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rsp_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data
);
	`include "broken_link_aging_table_assert.svh"

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	req_t req_q;
	logic [31:0] lifetime_q, delete_q, counter_q;
	logic [TABLE_ENTRIES-1:0] used_q;
	logic [CNT_W-1:0] rd_q;       // next slot to read
	logic [IDX_W-1:0] cur_s1;      // slot whose data arrives now
	logic vld_s1;
	logic best_ok_q;
	logic [IDX_W-1:0] best_q;
	entry_t best_e_q;
	logic [31:0] best_age_q;
	logic [5:0] exp_q, rem_q;
	logic free_ok_q;
	logic [IDX_W-1:0] free_q;

	entry_t rd_e, wr_e;
	logic we;
	logic [IDX_W-1:0] waddr;
	logic [31:0] age;
	logic [31:0] dl_diff;
	logic match, passed;
	logic done_ok;
	rsp_t rsp_d;

	blat_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wr_e),
		.raddr(rd_q[IDX_W-1:0]), .rdata(rd_e)
	);

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// walk is finished and the output register is free
	assign done_ok = (state_q == S_DONE) && (!out_valid || out_ready);

	// per slot compare on the arriving read data
	assign age = counter_q - rd_e.stamp;
	assign match = used_q[cur_s1] && (rd_e.dst == req_q.dst_addr) &&
		((req_q.cmd == CMD_FIND_D) || (rd_e.src == req_q.src_addr));
	// deadline before now, modulo 2^32
	assign dl_diff = rd_e.deadline - req_q.now_time;
	assign passed = dl_diff[31];

	// write port: sweep expiry during scan, insert or expire at done
	always_comb begin
		we = 1'b0;
		waddr = cur_s1;
		wr_e = rd_e;
		if (state_q == S_SCAN && vld_s1 && req_q.cmd == CMD_SWEEP &&
				used_q[cur_s1] && passed && rd_e.active) begin
			we = 1'b1;
			wr_e.active = 1'b0;
			wr_e.deadline = req_q.now_time + delete_q;
		end else if (done_ok) begin
			if (req_q.cmd == CMD_INSERT && free_ok_q) begin
				we = 1'b1;
				waddr = free_q;
				wr_e.active = 1'b1;
				wr_e.src = req_q.src_addr;
				wr_e.dst = req_q.dst_addr;
				wr_e.prev_hop = req_q.prev_hop;
				wr_e.last_available = req_q.last_available;
				wr_e.deadline = req_q.now_time + lifetime_q;
				wr_e.stamp = counter_q;
			end else if (req_q.cmd == CMD_EXPIRE && best_ok_q) begin
				we = 1'b1;
				waddr = best_q;
				wr_e = best_e_q;
				wr_e.active = 1'b0;
				wr_e.deadline = req_q.now_time + delete_q;
			end
		end
	end

	// response built from the walk results
	always_comb begin
		rsp_d = '0;
		unique case (req_q.cmd)
			CMD_INSERT: begin
				if (free_ok_q) begin
					rsp_d.status = ST_OK;
					rsp_d.hit_src = req_q.src_addr;
					rsp_d.hit_dst = req_q.dst_addr;
					rsp_d.hit_prev_hop = req_q.prev_hop;
					rsp_d.hit_last_available = req_q.last_available;
					rsp_d.hit_active = 1'b1;
					rsp_d.hit_lifetime = req_q.now_time + lifetime_q;
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			CMD_FIND_SD, CMD_FIND_D, CMD_EXPIRE: begin
				if (best_ok_q) begin
					rsp_d.status = ST_OK;
					rsp_d.hit_src = best_e_q.src;
					rsp_d.hit_dst = best_e_q.dst;
					rsp_d.hit_prev_hop = best_e_q.prev_hop;
					rsp_d.hit_last_available = best_e_q.last_available;
					rsp_d.hit_active = (req_q.cmd == CMD_EXPIRE) ?
						1'b0 : best_e_q.active;
					rsp_d.hit_lifetime = (req_q.cmd == CMD_EXPIRE) ?
						req_q.now_time + delete_q : best_e_q.deadline;
				end else begin
					rsp_d.status = ST_NOT_FOUND;
				end
			end
			CMD_SWEEP: begin
				rsp_d.status = ST_OK;
				rsp_d.expired_count = exp_q;
				rsp_d.removed_count = rem_q;
			end
			CMD_CLEAR: begin
				rsp_d.status = ST_OK;
				rsp_d.removed_count = rem_q;
			end
			default: rsp_d.status = ST_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			lifetime_q <= 32'd3000;
			delete_q <= 32'd15000;
			counter_q <= '0;
			used_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			rd_q <= '0;
			cur_s1 <= '0;
			vld_s1 <= 1'b0;
			best_ok_q <= 1'b0;
			best_q <= '0;
			best_e_q <= '0;
			best_age_q <= '0;
			exp_q <= '0;
			rem_q <= '0;
			free_ok_q <= 1'b0;
			free_q <= '0;
		end else begin
			if (out_valid && out_ready && !done_ok) begin
				out_valid <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LIFETIME) lifetime_q <= cfg_data;
				else delete_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (in_valid && in_ready) begin
						req_q <= in_data;
						state_q <= S_SCAN;
						rd_q <= '0;
						best_ok_q <= 1'b0;
						free_ok_q <= 1'b0;
						exp_q <= '0;
						rem_q <= '0;
					end
				end
				S_SCAN: begin
					vld_s1 <= (rd_q < CNT_W'(TABLE_ENTRIES));
					cur_s1 <= rd_q[IDX_W-1:0];
					if (rd_q < CNT_W'(TABLE_ENTRIES)) rd_q <= rd_q + 1'b1;
					if (vld_s1) begin
						if (!used_q[cur_s1] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q <= cur_s1;
						end
						if (match && (!best_ok_q || age < best_age_q)) begin
							best_ok_q <= 1'b1;
							best_q <= cur_s1;
							best_e_q <= rd_e;
							best_age_q <= age;
						end
						if (req_q.cmd == CMD_SWEEP && used_q[cur_s1] && passed) begin
							if (rd_e.active) exp_q <= exp_q + 1'b1;
							else begin
								rem_q <= rem_q + 1'b1;
								used_q[cur_s1] <= 1'b0;
							end
						end
						if (req_q.cmd == CMD_CLEAR && used_q[cur_s1]) begin
							rem_q <= rem_q + 1'b1;
							used_q[cur_s1] <= 1'b0;
						end
					end
					if (vld_s1 && cur_s1 == IDX_W'(TABLE_ENTRIES - 1)) state_q <= S_DONE;
				end
				S_DONE: begin
					// hold here while an earlier response still waits
					if (done_ok) begin
						state_q <= S_IDLE;
						out_valid <= 1'b1;
						out_data <= rsp_d;
						if (req_q.cmd == CMD_INSERT && free_ok_q) begin
							used_q[free_q] <= 1'b1;
							counter_q <= counter_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BLAT_ASSERT_NEXT(a_done_gives_resp, done_ok, out_valid)
	`BLAT_ASSERT_NEXT(a_no_take_while_busy, (state_q == S_SCAN), !in_ready)
	`BLAT_ASSERT_NEXT(a_insert_sets_used,
		(done_ok && req_q.cmd == CMD_INSERT && free_ok_q), used_q[$past(free_q)])
	`BLAT_ASSERT_NEXT(a_resp_held, (out_valid && !out_ready), (out_valid && $stable(out_data)))
endmodule
